[hw/rtl/ffr_pkg.sv]
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared beat types, codes and field widths of the first-fit free run finder.
// ----------------------------------------------------------------------------
package ffr_pkg;

	// field widths fixed by the beat formats
	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 13;
	localparam int ANSWER_W = 13;
	localparam int STATUS_W = 2;
	// run length carried between words, saturates at the largest run length
	localparam int RUN_W    = 13;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

	// request beat
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  value;
	} req_beat_t;

	// response beat
	typedef struct packed {
		logic [ANSWER_W-1:0] answer;
		logic [STATUS_W-1:0] status;
	} rsp_beat_t;

	// word scan status flags
	typedef struct packed {
		logic hit;       // a run of the asked length completes in this word
		logic occupied;  // the word holds at least one occupied position
	} scan_flags_t;

endpackage

[hw/rtl/ffr_map_ram.sv]
// ----------------------------------------------------------------------------
// ffr_map_ram
// Occupancy map storage: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ffr_map_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ffr_word_scan.sv]
// ----------------------------------------------------------------------------
// ffr_word_scan
// Shared scan unit: finds where a free run of the asked length first
// completes in one map word, given the free run carried in from below.
// ----------------------------------------------------------------------------
module ffr_word_scan import ffr_pkg::*; #(
	parameter int WORD_BITS = 64,
	parameter int BW        = 6
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [RUN_W-1:0]     run_in,
	input  logic [VALUE_W-1:0]   len,
	output scan_flags_t          flags,
	output logic [BW-1:0]        hit_bit,
	output logic [BW-1:0]        top_bit,
	output logic [RUN_W-1:0]     run_out
);

	localparam int LV = BW;

	logic                 has_l [LV+1][WORD_BITS];
	logic [BW-1:0]        pos_l [LV+1][WORD_BITS];
	logic [WORD_BITS-1:0] fit;
	logic [RUN_W:0]       run_sum;

	// prefix scan: highest occupied bit at or below each bit
	always_comb begin
		int src;
		for (int e = 0; e < WORD_BITS; e++) begin
			has_l[0][e] = word[e];
			pos_l[0][e] = BW'(e);
		end
		for (int j = 0; j < LV; j++) begin
			for (int e = 0; e < WORD_BITS; e++) begin
				src = (e >= (1 << j)) ? e - (1 << j) : e;
				if (!has_l[j][e] && e >= (1 << j)) begin
					has_l[j+1][e] = has_l[j][src];
					pos_l[j+1][e] = pos_l[j][src];
				end else begin
					has_l[j+1][e] = has_l[j][e];
					pos_l[j+1][e] = pos_l[j][e];
				end
			end
		end
	end

	// run length ending at each bit compared with the asked length
	always_comb begin
		logic [BW:0]    free_len;
		logic [RUN_W:0] sum;
		for (int e = 0; e < WORD_BITS; e++) begin
			free_len = (BW+1)'(e) - {1'b0, pos_l[LV][e]};
			sum      = {1'b0, run_in} + (RUN_W+1)'(e) + (RUN_W+1)'(1);
			if (has_l[LV][e]) begin
				fit[e] = (VALUE_W'(free_len) >= len);
			end else begin
				fit[e] = (sum >= {1'b0, len});
			end
		end
	end

	// lowest bit where the run completes
	always_comb begin
		hit_bit = '0;
		for (int e = WORD_BITS - 1; e >= 0; e--) begin
			if (fit[e]) begin
				hit_bit = BW'(e);
			end
		end
	end

	// run carried to the next word, saturating
	assign run_sum = {1'b0, run_in} + (RUN_W+1)'(WORD_BITS);

	always_comb begin
		if (has_l[LV][WORD_BITS-1]) begin
			run_out = RUN_W'((BW+1)'(WORD_BITS - 1) - {1'b0, pos_l[LV][WORD_BITS-1]});
		end else if (run_sum[RUN_W]) begin
			run_out = '1;
		end else begin
			run_out = run_sum[RUN_W-1:0];
		end
	end

	assign flags.hit      = |fit;
	assign flags.occupied = has_l[LV][WORD_BITS-1];
	assign top_bit        = pos_l[LV][WORD_BITS-1];

endmodule

[hw/rtl/first_fit_free_run_finder_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_free_run_finder_unit
// Occupancy map of positions 1..UNIVERSE with insert, remove and first-fit
// free run query, scanned one map word per cycle by a shared scan unit.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload | beat
//  --------+-----------+-----------+---------+------------------------------
//  request | req_valid | req_stall | req     | action and value
//  result  | rsp_valid | rsp_stall | rsp     | answer and status
//
//  After reset the map is cleared, one word per cycle, with req_stall high.
//  Insert and remove: word and bit split (ST_SPLIT1..ST_SPLIT3), then RMW in ST_READ.
//  Query: one map word per cycle, stopping at the first fit.
//  Invalid positions, unused actions and zero-length queries finish from idle, with no map access.
//  One beat at a time; the next request is taken while the last result waits.
//
module first_fit_free_run_finder_unit import ffr_pkg::*; #(
	parameter int UNIVERSE  = 4096,
	parameter int WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int DEPTH = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int IDXW  = $clog2(UNIVERSE);
	localparam int XW0   = $clog2(UNIVERSE + 2 * WORD_BITS + 2);
	localparam int XW    = (XW0 < 14) ? 14 : XW0;
	// reciprocal of WORD_BITS for the word and bit split
	localparam int SH    = IDXW + 7;
	localparam int MW    = SH - 2;
	localparam int MUL   = (2 ** SH) / WORD_BITS;
	localparam int PRW   = IDXW + MW;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT1,
		ST_SPLIT2,
		ST_SPLIT3,
		ST_READ,
		ST_SCAN0,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [AW-1:0]       clr_q;
	logic [ACTION_W-1:0] act_q;
	logic [VALUE_W-1:0]  k_q;
	logic [IDXW-1:0]     idx_q;
	logic [PRW-1:0]      prod_q;
	logic [AW-1:0]       quo_q;
	logic [BW:0]         rem_q;
	logic [AW-1:0]       word_q;
	logic [BW-1:0]       bit_q;
	logic [AW-1:0]       wrd_q;
	logic [XW-1:0]       base_q;
	logic [RUN_W-1:0]    run_q;
	logic [XW-1:0]       last_q;
	rsp_beat_t           res_q;
	rsp_beat_t           rsp_q;
	logic                rsp_valid_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	scan_flags_t      flags;
	logic [BW-1:0]    hit_bit;
	logic [BW-1:0]    top_bit;
	logic [RUN_W-1:0] run_out;

	logic                 in_range;
	logic [IDXW-1:0]      quo_w;
	logic [IDXW-1:0]      rem_w;
	logic [AW-1:0]        fix_word;
	logic [BW-1:0]        fix_bit;
	logic                 cur_bit;
	logic                 write_ok;
	logic [WORD_BITS-1:0] bit_mask;

	// occupancy map storage
	ffr_map_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.WIDTH(WORD_BITS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// shared word scan unit
	ffr_word_scan #(
		.WORD_BITS(WORD_BITS),
		.BW       (BW)
	) u_scan (
		.word   (mem_rdata),
		.run_in (run_q),
		.len    (k_q),
		.flags  (flags),
		.hit_bit(hit_bit),
		.top_bit(top_bit),
		.run_out(run_out)
	);

	// position range check on the request beat
	assign in_range = (32'(req.value) >= 32'd1) && (32'(req.value) <= 32'(UNIVERSE));

	// word and bit split from the reciprocal product
	assign quo_w = IDXW'(prod_q[PRW-1:SH]) * IDXW'(WORD_BITS);
	assign rem_w = idx_q - quo_w;

	always_comb begin
		if (rem_q >= (BW+1)'(WORD_BITS)) begin
			fix_word = quo_q + AW'(1);
			fix_bit  = BW'(rem_q - (BW+1)'(WORD_BITS));
		end else begin
			fix_word = quo_q;
			fix_bit  = BW'(rem_q);
		end
	end

	// read-modify-write of one map bit
	assign bit_mask = WORD_BITS'(1) << bit_q;
	assign cur_bit  = mem_rdata[bit_q];
	assign write_ok = (act_q == ACT_INSERT) ? !cur_bit : cur_bit;

	// map write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_READ: begin
				mem_we    = !done_q && write_ok;
				mem_wdata = (act_q == ACT_INSERT) ? (mem_rdata | bit_mask)
				                                  : (mem_rdata & ~bit_mask);
			end
			default: begin
			end
		endcase
	end

	// map read port
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_SPLIT3: begin
				mem_re    = 1'b1;
				mem_raddr = fix_word;
			end
			ST_SCAN0: begin
				mem_re = 1'b1;
			end
			ST_SCAN: begin
				mem_re    = !done_q && (wrd_q != LAST);
				mem_raddr = wrd_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			done_q      <= 1'b0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (done_q) begin
				// hand the finished result to the output register
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q       <= res_q;
					rsp_valid_q <= 1'b1;
					done_q      <= 1'b0;
					state_q     <= ST_IDLE;
				end
			end else begin
				// output register empties once its beat is taken
				if (rsp_valid_q && !rsp_stall) begin
					rsp_valid_q <= 1'b0;
				end
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == LAST) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (req_valid) begin
							act_q <= req.action;
							k_q   <= req.value;
							idx_q <= IDXW'(32'(req.value) - 32'd1);
							unique case (req.action) inside
								ACT_INSERT, ACT_REMOVE: begin
									res_q <= '{answer: '0, status: STAT_OK};
									if (in_range) begin
										state_q <= ST_SPLIT1;
									end else begin
										done_q <= 1'b1;
									end
								end
								ACT_QUERY: begin
									if (req.value == '0) begin
										res_q  <= '{answer: ANSWER_W'(1), status: STAT_OK};
										done_q <= 1'b1;
									end else begin
										res_q   <= '{answer: '0, status: STAT_OK};
										state_q <= ST_SCAN0;
									end
								end
								default: begin
									res_q  <= '{answer: '0, status: STAT_OK};
									done_q <= 1'b1;
								end
							endcase
						end
					end
					ST_SPLIT1: begin
						prod_q  <= PRW'(idx_q) * PRW'(MUL);
						state_q <= ST_SPLIT2;
					end
					ST_SPLIT2: begin
						quo_q   <= AW'(prod_q[PRW-1:SH]);
						rem_q   <= (BW+1)'(rem_w);
						state_q <= ST_SPLIT3;
					end
					ST_SPLIT3: begin
						word_q  <= fix_word;
						bit_q   <= fix_bit;
						state_q <= ST_READ;
					end
					ST_READ: begin
						if (!write_ok) begin
							res_q.status <= (act_q == ACT_INSERT) ? STAT_DUP : STAT_ABSENT;
						end
						done_q <= 1'b1;
					end
					ST_SCAN0: begin
						wrd_q   <= '0;
						base_q  <= '0;
						run_q   <= '0;
						last_q  <= '0;
						state_q <= ST_SCAN;
					end
					ST_SCAN: begin
						if (flags.hit) begin
							res_q.answer <= ANSWER_W'(base_q + XW'(hit_bit) + XW'(2) - XW'(k_q));
							done_q       <= 1'b1;
						end else begin
							run_q <= run_out;
							if (flags.occupied) begin
								last_q <= base_q + XW'(top_bit) + XW'(1);
							end
							if (wrd_q == LAST) begin
								// no fit inside the map: run starts after the last occupied
								if (flags.occupied) begin
									res_q.answer <= ANSWER_W'(base_q + XW'(top_bit) + XW'(2));
								end else begin
									res_q.answer <= ANSWER_W'(last_q + XW'(1));
								end
								done_q <= 1'b1;
							end else begin
								wrd_q  <= wrd_q + AW'(1);
								base_q <= base_q + XW'(WORD_BITS);
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE) || done_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// the query scan never writes the map
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("map written during query scan");

	// scanned word stays inside the map
	a_scan_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (wrd_q <= LAST))
		else $error("scan word index beyond map");

	// corrected split leaves a bit index inside the word
	a_bit_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ((BW+1)'(bit_q) < (BW+1)'(WORD_BITS)))
		else $error("bit index beyond word width");

	// an insert of an absent position writes the map
	a_insert_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && !done_q && act_q == ACT_INSERT && !cur_bit) |-> mem_we)
		else $error("insert of absent position not written");

	// a finished result waits while the output register is held
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_valid_q && rsp_stall) |=> done_q)
		else $error("result dropped while output stalled");
`endif

endmodule

[verif/tb_first_fit_free_run_finder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_free_run_finder_unit
// Self-checking bench for the first-fit free run finder. A directed table
// covers empty-map queries, duplicate and absent positions, ignored
// positions, the unused action and runs past the top of the map. A random
// part follows, with inserts and removes focused on a moving window so that
// queries meet crowded and fragmented maps. Every result beat is compared
// with the table answer or a local occupancy map model.
// ----------------------------------------------------------------------------
module tb_first_fit_free_run_finder_unit;
	import ffr_pkg::*;

	localparam int UNIVERSE     = 4096;
	localparam int WORD_BITS    = 64;
	localparam int DEPTH        = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
	localparam int TAIL_CYCLES  = DEPTH + 16;
	localparam int RANDOM_ITEMS = 1850;
	localparam int MAX_PRINTS   = 40;
	localparam int VALUE_MAX    = (1 << VALUE_W) - 1;

	// the one action code without a meaning
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		req_beat_t beat;
		logic      typed;
		rsp_beat_t want;
	} table_row_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// model state and bookkeeping
	bit          occ_map [1:UNIVERSE];
	rsp_beat_t   due_rsp_q [$];
	table_row_t  dir_rows [$];
	rsp_beat_t   head_rsp;
	int unsigned bad_beat_count = 0;
	bit          quiet = 1'b0;
	int unsigned win_lo = 1;
	int unsigned win_len = 64;

	first_fit_free_run_finder_unit #(
		.UNIVERSE (UNIVERSE),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop for a hung run
	initial begin
		#12_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// lowest start of k free positions, positions past the map count as free
	function automatic logic [ANSWER_W-1:0] first_fit_start(int unsigned k);
		int unsigned start = 1;
		int unsigned run = 0;
		if (k == 0)
			return ANSWER_W'(1);
		for (int unsigned p = 1; p <= UNIVERSE; p++) begin
			if (occ_map[p]) begin
				run = 0;
				start = p + 1;
			end else begin
				run++;
				if (run >= k)
					return start[ANSWER_W-1:0];
			end
		end
		return start[ANSWER_W-1:0];
	endfunction

	// apply one request to the map and return the response it should give
	function automatic rsp_beat_t apply_to_map(req_beat_t b);
		rsp_beat_t   r;
		int unsigned v;
		bit          in_range;
		r = '0;
		v = 32'(b.value);
		in_range = (v >= 1) && (v <= UNIVERSE);
		case (b.action)
			ACT_INSERT: begin
				if (in_range) begin
					if (occ_map[v])
						r.status = STAT_DUP;
					else
						occ_map[v] = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (in_range) begin
					if (!occ_map[v])
						r.status = STAT_ABSENT;
					else
						occ_map[v] = 1'b0;
				end
			end
			ACT_QUERY: begin
				r.answer = first_fit_start(v);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (bad_beat_count < MAX_PRINTS)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		bad_beat_count++;
	endtask

	task automatic add_row(logic [ACTION_W-1:0] action, int unsigned value, bit typed,
			int unsigned answer, logic [STATUS_W-1:0] status);
		table_row_t row;
		row.beat.action = action;
		row.beat.value  = value[VALUE_W-1:0];
		row.typed       = typed;
		row.want.answer = answer[ANSWER_W-1:0];
		row.want.status = status;
		dir_rows.push_back(row);
	endtask

	// present one request beat, hold it until taken, then log its response
	task automatic send_beat(req_beat_t b, bit typed, rsp_beat_t want);
		rsp_beat_t predicted;
		while (!quiet && $urandom_range(0, 99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = apply_to_map(b);
		due_rsp_q.push_back(typed ? want : predicted);
	endtask

	// hold off requests until every response is back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// mostly inside the current window, now and then anywhere in the map
	function automatic int unsigned pick_pos();
		if ($urandom_range(0, 99) < 85)
			return win_lo + $urandom_range(0, win_len - 1);
		return $urandom_range(1, UNIVERSE);
	endfunction

	task automatic move_window();
		case ($urandom_range(0, 3))
			0: win_len = 16;
			1: win_len = 64;
			2: win_len = 130;
			default: win_len = 512;
		endcase
		case ($urandom_range(0, 2))
			0: win_lo = 1;
			1: win_lo = UNIVERSE - win_len + 1;
			default: win_lo = $urandom_range(1, UNIVERSE - win_len + 1);
		endcase
	endtask

	// one random request; ignored ones do not count toward the item total
	task automatic random_beat(output req_beat_t b, output bit counted);
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < 40) begin
			b.action = ACT_INSERT;
			v = pick_pos();
		end else if (r < 58) begin
			// lean toward removing positions that are present
			b.action = ACT_REMOVE;
			v = pick_pos();
			for (int t = 0; t < 8 && !occ_map[v] && $urandom_range(0, 3) != 0; t++)
				v = pick_pos();
		end else if (r < 92) begin
			b.action = ACT_QUERY;
			r = $urandom_range(0, 99);
			if (r < 55)
				v = $urandom_range(1, 8);
			else if (r < 80)
				v = $urandom_range(1, 64);
			else if (r < 92)
				v = $urandom_range(65, UNIVERSE);
			else if (r < 97)
				v = $urandom_range(UNIVERSE + 1, VALUE_MAX);
			else
				v = 0;
		end else begin
			counted = 1'b0;
			case ($urandom_range(0, 2))
				0: begin
					b.action = ACT_UNUSED;
					v = $urandom_range(0, VALUE_MAX);
				end
				1: begin
					b.action = $urandom_range(0, 1) ? ACT_INSERT : ACT_REMOVE;
					v = 0;
				end
				default: begin
					b.action = $urandom_range(0, 1) ? ACT_INSERT : ACT_REMOVE;
					v = $urandom_range(UNIVERSE + 1, VALUE_MAX);
				end
			endcase
		end
		b.value = v[VALUE_W-1:0];
	endtask

	// result side stall
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(0, 99) < 24);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp_q.size() == 0) begin
				report_mismatch("result beat with nothing pending, answer",
					32'(rsp.answer), 0);
			end else begin
				head_rsp = due_rsp_q.pop_front();
				if (rsp.answer !== head_rsp.answer)
					report_mismatch("answer", 32'(rsp.answer), 32'(head_rsp.answer));
				if (rsp.status !== head_rsp.status)
					report_mismatch("status", 32'(rsp.status), 32'(head_rsp.status));
			end
		end
	end

	// stimulus
	initial begin
		req_beat_t   b;
		rsp_beat_t   no_rsp;
		bit          counted;
		int unsigned counted_items;
		int unsigned item_idx;

		no_rsp = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: empty map, errors, ignored items, runs past the top
		add_row(ACT_QUERY,  1,         1, 1,            STAT_OK);
		add_row(ACT_QUERY,  0,         1, 1,            STAT_OK);
		add_row(ACT_QUERY,  VALUE_MAX, 1, 1,            STAT_OK);
		add_row(ACT_INSERT, 1,         1, 0,            STAT_OK);
		add_row(ACT_INSERT, 1,         1, 0,            STAT_DUP);
		add_row(ACT_REMOVE, 2,         1, 0,            STAT_ABSENT);
		add_row(ACT_INSERT, UNIVERSE,  1, 0,            STAT_OK);
		add_row(ACT_QUERY,  VALUE_MAX, 1, UNIVERSE + 1, STAT_OK);
		add_row(ACT_QUERY,  1,         1, 2,            STAT_OK);
		add_row(ACT_INSERT, 0,         1, 0,            STAT_OK);
		add_row(ACT_INSERT, UNIVERSE + 1, 1, 0,         STAT_OK);
		add_row(ACT_REMOVE, VALUE_MAX, 1, 0,            STAT_OK);
		add_row(ACT_REMOVE, 0,         1, 0,            STAT_OK);
		add_row(ACT_UNUSED, VALUE_MAX, 1, 0,            STAT_OK);
		add_row(ACT_UNUSED, 0,         1, 0,            STAT_OK);
		add_row(ACT_INSERT, 2,            0, 0, STAT_OK);
		add_row(ACT_INSERT, 3,            0, 0, STAT_OK);
		add_row(ACT_QUERY,  UNIVERSE - 4, 0, 0, STAT_OK);
		add_row(ACT_QUERY,  UNIVERSE - 3, 0, 0, STAT_OK);
		add_row(ACT_REMOVE, UNIVERSE,     0, 0, STAT_OK);
		add_row(ACT_QUERY,  UNIVERSE - 3, 0, 0, STAT_OK);
		add_row(ACT_INSERT, WORD_BITS,     0, 0, STAT_OK);
		add_row(ACT_INSERT, WORD_BITS + 1, 0, 0, STAT_OK);
		add_row(ACT_QUERY,  WORD_BITS - 3, 0, 0, STAT_OK);
		add_row(ACT_REMOVE, 1,            0, 0, STAT_OK);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
		drain_responses();

		// random part, window moves every 150 beats
		counted_items = 0;
		item_idx = 0;
		while (counted_items < RANDOM_ITEMS) begin
			if (item_idx % 150 == 0)
				move_window();
			if (item_idx == 900)
				drain_responses();
			quiet = (counted_items >= 1200) && (counted_items < 1500);
			random_beat(b, counted);
			send_beat(b, 1'b0, no_rsp);
			item_idx++;
			if (counted)
				counted_items++;
		end
		quiet = 1'b0;

		// wait out the last responses plus a tail for strays
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_rsp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_beat_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ffr_pkg.sv
hw/rtl/ffr_map_ram.sv
hw/rtl/ffr_word_scan.sv
hw/rtl/first_fit_free_run_finder_unit.sv
verif/tb_first_fit_free_run_finder_unit.sv
